// ===== rtl/sjd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjd_pkg
// Shared types, field widths and helpers for the skeleton junction detector.
// ----------------------------------------------------------------------------
package sjd_pkg;

    // Field widths
    localparam int PIX_W  = 8;
    localparam int X_W    = 10;
    localparam int Y_W    = 12;
    localparam int CFG_DW = 13;
    localparam int CFG_AW = 2;

    // Junction threshold on the ring crossing count
    localparam logic [3:0] MIN_CROSSINGS = 4'd6;

    // Configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1
    } t_cfg_idx;

    // One window column, top to bottom
    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
    } t_col;

    // One line store entry: the two previous rows at a column
    typedef struct packed {
        logic upper;
        logic middle;
    } t_ls_word;

    // Count value changes walking down a column (top-mid, mid-bot)
    function automatic logic [1:0] f_vcross(input t_col col);
        f_vcross = {1'b0, col.top ^ col.mid} + {1'b0, col.mid ^ col.bot};
    endfunction

endpackage

// ===== rtl/skeleton_junction_detector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skeleton_junction_detector_top
// Crossing-number junction test on a 3x3 window over a binary pixel stream.
// ----------------------------------------------------------------------------
// Path: an accepted pixel and its line store read are registered in stage 1, then the result word in the output word.
// Throughput: one pixel word per cycle, set by the single line store read port
//   and the two-cell window chain; stalls only while a result word is held.
// Reset: clears counters, window cells and valid flags; width and height go to
//   640 (MAX_WIDTH if smaller) and 480. The line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module skeleton_junction_detector_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // pixel channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [sjd_pkg::PIX_W-1:0]   i_pixel,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [sjd_pkg::X_W-1:0]     o_junction_x,
    output logic [sjd_pkg::Y_W-1:0]     o_junction_y,
    output logic                        o_is_junction,
    output logic                        o_frame_end,
    // configuration channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [sjd_pkg::CFG_AW-1:0]  i_cfg_index,
    input  logic [sjd_pkg::CFG_DW-1:0]  i_cfg_data
);

    localparam int          AW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int          NCELL    = 2;
    localparam logic [12:0] WMax     = 13'(MAX_WIDTH);
    localparam logic [11:0] WLastRst = (MAX_WIDTH < 640) ? 12'(MAX_WIDTH - 1) : 12'd639;
    localparam logic [11:0] HLastRst = 12'd479;

    // Config state: last column and last row indexes, already clamped
    logic [11:0] r_wlast, n_wlast;
    logic [11:0] r_hlast, n_hlast;
    logic [12:0] w_raw, w_cl, h_cl;

    // Raster counters
    logic [sjd_pkg::X_W-1:0] r_x, n_x;
    logic [sjd_pkg::Y_W-1:0] r_y, n_y;
    logic                    last_px;

    // Stage 1 (line store read in flight)
    logic                    r1_valid;
    logic                    r1_cur;
    logic [sjd_pkg::X_W-1:0] r1_x;
    logic [sjd_pkg::Y_W-1:0] r1_y;
    logic                    r1_last;

    // Output word
    logic                    r_o_valid;
    logic [sjd_pkg::X_W-1:0] r_o_x;
    logic [sjd_pkg::Y_W-1:0] r_o_y;
    logic                    r_o_junc;
    logic                    r_o_end;

    logic en, acc, adv;

    sjd_pkg::t_ls_word ls_rdata, ls_wdata;
    sjd_pkg::t_col     new_col;
    sjd_pkg::t_col     cell_in   [NCELL];
    sjd_pkg::t_col     cell_out  [NCELL];
    logic [1:0]        cell_vx   [NCELL];
    logic [3:0]        crossings;
    logic              junc;

    // Pipeline moves whenever the output word is free or being taken
    assign en      = !r_o_valid || !i_stall;
    assign acc     = i_valid && en;
    assign adv     = r1_valid && en;
    assign o_stall = !en;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    // Clamp width to [3, MAX_WIDTH] and height to [3, 4096]
    always_comb begin
        w_raw   = {2'b00, i_cfg_data[10:0]};
        w_cl    = (w_raw < 13'd3) ? 13'd3 : ((w_raw > WMax) ? WMax : w_raw);
        h_cl    = (i_cfg_data < 13'd3) ? 13'd3 :
                  ((i_cfg_data > 13'd4096) ? 13'd4096 : i_cfg_data);
        n_wlast = 12'(w_cl - 13'd1);
        n_hlast = 12'(h_cl - 13'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast <= WLastRst;
            r_hlast <= HLastRst;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sjd_pkg::CFG_WIDTH:  r_wlast <= n_wlast;
                sjd_pkg::CFG_HEIGHT: r_hlast <= n_hlast;
                default: ;
            endcase
        end
    end

    // ---------------- raster position ----------------
    // Advance column, wrap at row end, flag the frame's final pixel
    always_comb begin
        n_x     = r_x + 10'd1;
        n_y     = r_y;
        last_px = 1'b0;
        if ({2'b00, r_x} >= r_wlast) begin
            n_x = '0;
            if (r_y >= r_hlast) begin
                n_y     = '0;
                last_px = 1'b1;
            end else begin
                n_y = r_y + 12'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (acc) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r1_cur  <= (i_pixel != '0);
            r1_x    <= r_x;
            r1_y    <= r_y;
            r1_last <= last_px;
        end
    end

    // Line store: read at accept, write back shifted rows as the word moves on
    assign ls_wdata.upper  = ls_rdata.middle;
    assign ls_wdata.middle = r1_cur;

    sjd_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_re    (acc),
        .i_raddr (AW'(r_x)),
        .o_rdata (ls_rdata),
        .i_we    (adv),
        .i_waddr (AW'(r1_x)),
        .i_wdata (ls_wdata)
    );

    // ---------------- window chain ----------------
    assign new_col.top = ls_rdata.upper;
    assign new_col.mid = ls_rdata.middle;
    assign new_col.bot = r1_cur;

    // Newest column enters cell 0, each cell passes its column leftward
    for (genvar c = 0; c < NCELL; c++) begin : g_cell
        if (c == 0) begin : g_head
            assign cell_in[c] = new_col;
        end else begin : g_body
            assign cell_in[c] = cell_out[c-1];
        end
        sjd_col_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (adv),
            .i_col    (cell_in[c]),
            .o_col    (cell_out[c]),
            .o_vcross (cell_vx[c])
        );
    end

    // Ring crossings of the shifted window: left = cell 1, centre = cell 0,
    // right = incoming column
    always_comb begin
        crossings = {2'b00, cell_vx[1]}
                  + {2'b00, sjd_pkg::f_vcross(new_col)}
                  + {3'b000, cell_out[1].bot ^ cell_out[0].bot}
                  + {3'b000, cell_out[0].bot ^ new_col.bot}
                  + {3'b000, new_col.top ^ cell_out[0].top}
                  + {3'b000, cell_out[0].top ^ cell_out[1].top};
        junc = (r1_x >= 10'd2) && (r1_y >= 12'd2) && cell_out[0].mid
            && (crossings >= sjd_pkg::MIN_CROSSINGS);
    end

    // ---------------- output word ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r1_valid && (junc || r1_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_x    <= junc ? (r1_x - 10'd1) : '0;
            r_o_y    <= junc ? (r1_y - 12'd1) : '0;
            r_o_junc <= junc;
            r_o_end  <= r1_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_junction_x  = r_o_x;
    assign o_junction_y  = r_o_y;
    assign o_is_junction = r_o_junc;
    assign o_frame_end   = r_o_end;

    // ---------------- assertions ----------------
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result word held");

    a_word_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_junction || o_frame_end))
        else $error("result word with neither junction nor frame end");

    a_junction_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_junction) |-> (o_junction_x != '0 && o_junction_y != '0))
        else $error("junction reported on a border pixel");

    a_frame_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_junction) |-> (o_junction_x == '0 && o_junction_y == '0))
        else $error("frame-end word carries nonzero coordinates");

    a_wrap_at_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && last_px) |=> (r_x == '0 && r_y == '0))
        else $error("raster counters did not wrap at frame end");

endmodule

// ===== rtl/sjd_line_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjd_line_store
// Two-row binary line store, one entry per column, registered read.
// ----------------------------------------------------------------------------
module sjd_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              i_clk,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output sjd_pkg::t_ls_word o_rdata,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  sjd_pkg::t_ls_word i_wdata
);

    sjd_pkg::t_ls_word r_mem [DEPTH];
    sjd_pkg::t_ls_word r_rdata;

    // Write the shifted column entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read on accept, hold while stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sjd_col_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjd_col_cell
// One window column cell: holds a column and passes it on to its neighbor.
// ----------------------------------------------------------------------------
module sjd_col_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  sjd_pkg::t_col i_col,
    output sjd_pkg::t_col o_col,
    output logic [1:0]    o_vcross
);

    sjd_pkg::t_col r_col;

    // Take the column from the right-hand neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col    = r_col;
    assign o_vcross = sjd_pkg::f_vcross(r_col);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the skeleton junction detector. Pixel words stream
// in raster order through a predictor that tracks the line stores, the 3x3
// window and the frame counters; every result word is compared field by
// field with the oldest predicted one. Covers hand-built frames, random
// frames of many sizes, clamped register values, width changes in mid-frame,
// the widest and tallest clamped sizes, idle bursts on both sides and a long
// result hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_W        = 1024;
    localparam int DRAIN_TAIL   = 8;
    localparam int LONG_HOLD    = 300;
    localparam int LIMIT_CYCLES = 800000;

    // Index with no register behind it; writes there must change nothing
    localparam logic [sjd_pkg::CFG_AW-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [sjd_pkg::X_W-1:0] x;
        logic [sjd_pkg::Y_W-1:0] y;
        logic                    junc;
        logic                    fend;
    } t_result;

    typedef enum int {
        FILL_SPARSE,
        FILL_HALF,
        FILL_DENSE,
        FILL_CHECKER,
        FILL_ROUGH_CHECKER
    } t_fill;

    // Junction predictor: line stores, window, counters and pending results
    class junction_tracker;
        bit [10:0]      width_reg;
        bit [12:0]      height_reg;
        bit             upper_row [MAX_W];
        bit             middle_row [MAX_W];
        bit [1:0]       write_count [MAX_W];
        bit [2:0]       win_top, win_mid, win_bot;
        int unsigned    col, row;
        t_result        pending_results [$];
        int             errors, n_pixels, n_results, n_junctions, n_frames;

        function new();
            width_reg  = 11'd640;
            height_reg = 13'd480;
        endfunction

        function int eff_width();
            if (width_reg < 3) return 3;
            if (width_reg > MAX_W) return MAX_W;
            return width_reg;
        endfunction

        function int eff_height();
            if (height_reg < 3) return 3;
            if (height_reg > 4096) return 4096;
            return height_reg;
        endfunction

        function void note_reg(logic [sjd_pkg::CFG_AW-1:0] idx,
                               logic [sjd_pkg::CFG_DW-1:0] data);
            case (idx)
                sjd_pkg::CFG_WIDTH: begin
                    width_reg = data[10:0];
                end
                sjd_pkg::CFG_HEIGHT: begin
                    height_reg = data[12:0];
                end
                default: begin
                end
            endcase
        endfunction

        // Columns whose upper and middle entries both hold written data
        function int settled_cols();
            int n;
            n = 0;
            while (n < MAX_W && write_count[n] == 2'd2) n++;
            return n;
        endfunction

        // Hold back a width growth that would pull unwritten entries into a tested window
        function int safe_width(int raw);
            int eff;
            eff = (raw < 3) ? 3 : (raw > MAX_W) ? MAX_W : raw;
            if ((col == 0 && row == 0) || eff <= settled_cols()) return raw;
            return settled_cols();
        endfunction

        function int to_frame_end();
            int w, h, n;
            w = eff_width();
            h = eff_height();
            n = (col >= w - 1) ? 1 : w - col;
            if (row < h - 1) n += (h - 1 - row) * w;
            return n;
        endfunction

        function void take_pixel(logic [sjd_pkg::PIX_W-1:0] px);
            int unsigned w, h, x0, y0;
            bit          cur, up, mid, junc, last;
            bit [7:0]    ring;
            t_result     r;
            w    = eff_width();
            h    = eff_height();
            x0   = col;
            y0   = row;
            last = 1'b0;
            cur  = (px != 0);
            up   = upper_row[col];
            mid  = middle_row[col];

            // Shift the window left and bring in the new column
            win_top = {win_top[1:0], up};
            win_mid = {win_mid[1:0], mid};
            win_bot = {win_bot[1:0], cur};
            upper_row[col]  = mid;
            middle_row[col] = cur;
            if (write_count[col] != 2'd2) write_count[col]++;

            // Ring from bit 0 up: TL, L, BL, B, BR, R, TR, T
            ring = {win_top[1], win_top[0], win_mid[0], win_bot[0],
                    win_bot[1], win_bot[2], win_mid[2], win_top[2]};
            junc = x0 >= 2 && y0 >= 2 && win_mid[1] &&
                   $countones(ring ^ {ring[0], ring[7:1]}) >= sjd_pkg::MIN_CROSSINGS;

            // Advance the raster position
            if (col >= w - 1) begin
                col = 0;
                if (row >= h - 1) begin
                    row  = 0;
                    last = 1'b1;
                end else begin
                    row++;
                end
            end else begin
                col++;
            end

            n_pixels++;
            if (junc || last) begin
                r.x  = junc ? sjd_pkg::X_W'(x0 - 1) : '0;
                r.y  = junc ? sjd_pkg::Y_W'(y0 - 1) : '0;
                r.junc = junc;
                r.fend = last;
                pending_results.push_back(r);
                if (junc) n_junctions++;
                if (last) n_frames++;
            end
        endfunction

        function void check_result(logic [sjd_pkg::X_W-1:0] x, logic [sjd_pkg::Y_W-1:0] y,
                                   logic junc, logic fend);
            t_result e;
            n_results++;
            if (pending_results.size() == 0) begin
                $error("unexpected result word: x=%0d y=%0d is_junction=%0b frame_end=%0b",
                       x, y, junc, fend);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (x !== e.x) begin
                $error("junction_x: expected %0d, got %0d", e.x, x);
                errors++;
            end
            if (y !== e.y) begin
                $error("junction_y: expected %0d, got %0d", e.y, y);
                errors++;
            end
            if (junc !== e.junc) begin
                $error("is_junction: expected %0b, got %0b", e.junc, junc);
                errors++;
            end
            if (fend !== e.fend) begin
                $error("frame_end: expected %0b, got %0b", e.fend, fend);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_valid     = 1'b0;
    logic                           o_stall;
    logic [sjd_pkg::PIX_W-1:0]      i_pixel     = '0;
    logic                           o_valid;
    logic                           i_stall     = 1'b0;
    logic [sjd_pkg::X_W-1:0]        o_junction_x;
    logic [sjd_pkg::Y_W-1:0]        o_junction_y;
    logic                           o_is_junction;
    logic                           o_frame_end;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [sjd_pkg::CFG_AW-1:0]     i_cfg_index = sjd_pkg::CFG_WIDTH;
    logic [sjd_pkg::CFG_DW-1:0]     i_cfg_data  = '0;

    junction_tracker    sb;
    bit                 tx_idle_on;
    bit                 rx_idle_on;
    bit                 rx_hold_req;
    int                 hold_left;
    int                 burst_left;
    int                 cycles;

    // Two frames: an eight-crossing star ending on the last pixel, then a bar
    localparam logic [sjd_pkg::PIX_W-1:0] STAR_AND_BAR [18] = '{
        8'd255, 8'd0,   8'd1,
        8'd0,   8'd128, 8'd0,
        8'd2,   8'd0,   8'd255,
        8'd0,   8'd255, 8'd0,
        8'd0,   8'd64,  8'd0,
        8'd0,   8'd255, 8'd0
    };

    skeleton_junction_detector_top #(
        .MAX_WIDTH(MAX_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel       (i_pixel),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_junction_x  (o_junction_x),
        .o_junction_y  (o_junction_y),
        .o_is_junction (o_is_junction),
        .o_frame_end   (o_frame_end),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drive result stall: long hold-off on request, else random bursts
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            hold_left   = LONG_HOLD;
            rx_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            i_stall <= 1'b1;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(0, 4);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Check every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_junction_x, o_junction_y, o_is_junction, o_frame_end);
        end
    end

    function automatic logic [sjd_pkg::PIX_W-1:0] pick_pixel(t_fill fill);
        bit on, parity;
        parity = ((sb.col + sb.row) % 2) == 0;
        case (fill)
            FILL_SPARSE:  on = ($urandom_range(0, 3) == 0);
            FILL_HALF:    on = 1'($urandom_range(0, 1));
            FILL_DENSE:   on = ($urandom_range(0, 7) != 0);
            FILL_CHECKER: on = parity;
            default:      on = parity ^ ($urandom_range(0, 7) == 0);
        endcase
        return on ? sjd_pkg::PIX_W'($urandom_range(1, 255)) : '0;
    endfunction

    task automatic send_pixel(input logic [sjd_pkg::PIX_W-1:0] px);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            @(negedge i_clk);
            i_valid <= 1'b0;
            i_pixel <= sjd_pkg::PIX_W'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.take_pixel(px);
    endtask

    task automatic stream_pixels(input int count, input t_fill fill);
        repeat (count) send_pixel(pick_pixel(fill));
    endtask

    // Drop valid, wait out every pending result, then let the pipeline empty
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sjd_pkg::CFG_AW-1:0] idx,
                             input logic [sjd_pkg::CFG_DW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.note_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Complete the current frame so the next one starts at the origin
    task automatic to_frame_start();
        drain();
        if (sb.col != 0 || sb.row != 0) begin
            stream_pixels(sb.to_frame_end(), FILL_HALF);
            drain();
        end
    endtask

    task automatic random_phase(input bit allow_idle, output int n);
        int    raw, frame_px;
        t_fill fill;
        drain();
        tx_idle_on = allow_idle && ($urandom_range(0, 3) != 0);
        rx_idle_on = allow_idle && ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
                0:       raw = $urandom_range(0, 2);
                1:       raw = $urandom_range(13, 40);
                default: raw = $urandom_range(3, 12);
            endcase
            write_reg(sjd_pkg::CFG_WIDTH,
                      {2'($urandom_range(0, 3)), 11'(sb.safe_width(raw))});
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
                0:       raw = $urandom_range(0, 2);
                1:       raw = $urandom_range(9, 20);
                default: raw = $urandom_range(3, 8);
            endcase
            write_reg(sjd_pkg::CFG_HEIGHT, sjd_pkg::CFG_DW'(raw));
        end
        fill     = t_fill'($urandom_range(0, 4));
        frame_px = sb.eff_width() * sb.eff_height();
        if ($urandom_range(0, 9) < 7) begin
            n = sb.to_frame_end();
            if ($urandom_range(0, 2) == 0) n += frame_px;
        end else begin
            n = $urandom_range(1, frame_px);
        end
        stream_pixels(n, fill);
    endtask

    initial begin
        int random_items, n;
        random_items = 0;
        sb = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: spare index, clamped low sizes, star and bar frames
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        write_reg(CFG_SPARE, '1);
        write_reg(sjd_pkg::CFG_WIDTH, sjd_pkg::CFG_DW'(0));
        write_reg(sjd_pkg::CFG_HEIGHT, sjd_pkg::CFG_DW'(1));
        foreach (STAR_AND_BAR[i]) send_pixel(STAR_AND_BAR[i]);
        drain();

        while (random_items < 150) begin
            random_phase(1'b1, n);
            random_items += n;
        end

        // Back up the block: checkerboard frame under a long result hold-off
        to_frame_start();
        write_reg(sjd_pkg::CFG_WIDTH, sjd_pkg::CFG_DW'(12));
        write_reg(sjd_pkg::CFG_HEIGHT, sjd_pkg::CFG_DW'(12));
        rx_hold_req = 1'b1;
        stream_pixels(144, FILL_CHECKER);
        drain();

        // Widest row, then tallest frame, both reached through clamping and cut short
        to_frame_start();
        write_reg(sjd_pkg::CFG_WIDTH, '1);
        write_reg(sjd_pkg::CFG_HEIGHT, sjd_pkg::CFG_DW'(0));
        stream_pixels(64, FILL_DENSE);
        drain();
        write_reg(sjd_pkg::CFG_WIDTH, sjd_pkg::CFG_DW'(1));
        write_reg(sjd_pkg::CFG_HEIGHT, '1);
        stream_pixels(30, FILL_HALF);
        drain();
        write_reg(sjd_pkg::CFG_HEIGHT, sjd_pkg::CFG_DW'(0));
        to_frame_start();

        while (random_items < 250) begin
            random_phase(1'b1, n);
            random_items += n;
        end
        while (random_items < 350) begin
            random_phase(1'b0, n);
            random_items += n;
        end
        drain();
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("Sent %0d pixel words over %0d frames; checked %0d result words, %0d junctions.",
                 sb.n_pixels, sb.n_frames, sb.n_results, sb.n_junctions);
        $display("Small random frames, clamped sizes up to 1024 by 4096, idle bursts and a hold-off.");
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
